### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, sampled on the rising clock edge and held off during reset.
`define RYCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define RYCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define RYCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rycc_pkg.sv
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
package rycc_pkg;

    localparam int PIX_W = 8;
    localparam int SUM_W = PIX_W + 1;
    localparam int CFG_W = 13;
    localparam int ROW_W = 12;
    localparam int MAX_HEIGHT = 4096;

    // Register indexes, taken from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // BT.709 limited-range coefficients in units of 1/256.
    localparam logic [15:0] LUMA_R_COEF = 16'd47;
    localparam logic [15:0] LUMA_G_COEF = 16'd157;
    localparam logic [15:0] LUMA_B_COEF = 16'd16;
    localparam logic [15:0] ROUND_HALF  = 16'd128;
    localparam logic [8:0]  LUMA_OFFSET = 9'd16;

    localparam logic [15:0] CB_R_COEF = 16'd26;   // subtracted
    localparam logic [15:0] CB_G_COEF = 16'd87;   // subtracted
    localparam logic [15:0] CB_B_COEF = 16'd112;
    localparam logic [15:0] CR_R_COEF = 16'd112;
    localparam logic [15:0] CR_G_COEF = 16'd102;  // subtracted
    localparam logic [15:0] CR_B_COEF = 16'd10;   // subtracted

    // Rounding term plus the 128 chroma offset placed above the binary point,
    // so the biased sum never goes negative.
    localparam logic [15:0] CHROMA_BIAS = ROUND_HALF + 16'd32768;

    localparam logic [9:0] AVG_ROUND = 10'd2;
    localparam logic [PIX_W-1:0] BYTE_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } pair_sum_t;

    typedef struct packed {
        logic chroma;
        logic frame_end;
    } stage_ctrl_t;

endpackage

### hw/rtl/rycc_line_store.sv
// Line store of top-row pair sums, one write or one registered read per cycle.
module rycc_line_store
    import rycc_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  pair_sum_t         wr_data,
    output pair_sum_t         rd_data
);

    pair_sum_t mem [DEPTH];
    pair_sum_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/rycc_color_math.sv
// Two-stage color math: luma and block averages, then chroma into the result register.
module rycc_color_math
    import rycc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pixel_t           in_pixel,
    input  pair_sum_t        in_pair,
    input  pair_sum_t        in_line,
    input  stage_ctrl_t      in_ctrl,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_luma,
    output logic             out_chroma_valid,
    output logic [PIX_W-1:0] out_cb,
    output logic [PIX_W-1:0] out_cr,
    output logic             out_frame_end
);

    logic             a_valid_reg;
    logic [PIX_W-1:0] a_luma_reg;
    logic [PIX_W-1:0] a_avg_r_reg;
    logic [PIX_W-1:0] a_avg_g_reg;
    logic [PIX_W-1:0] a_avg_b_reg;
    stage_ctrl_t      a_ctrl_reg;

    logic             b_valid_reg;
    logic [PIX_W-1:0] b_luma_reg;
    logic             b_chroma_reg;
    logic [PIX_W-1:0] b_cb_reg;
    logic [PIX_W-1:0] b_cr_reg;
    logic             b_frame_end_reg;

    logic             a_ready;
    logic [15:0]      luma_sum;
    logic [8:0]       luma_off;
    logic [PIX_W-1:0] luma_next;
    logic [9:0]       avg_r_sum;
    logic [9:0]       avg_g_sum;
    logic [9:0]       avg_b_sum;
    logic [15:0]      cb_sum;
    logic [15:0]      cr_sum;

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_comb
    begin
        luma_sum = LUMA_R_COEF * 16'(in_pixel.red) + LUMA_G_COEF * 16'(in_pixel.green)
                 + LUMA_B_COEF * 16'(in_pixel.blue) + ROUND_HALF;
        luma_off = {1'b0, luma_sum[15:8]} + LUMA_OFFSET;
        luma_next = luma_off[8] ? BYTE_MAX : luma_off[7:0];
        avg_r_sum = 10'(in_pair.red) + 10'(in_line.red) + AVG_ROUND;
        avg_g_sum = 10'(in_pair.green) + 10'(in_line.green) + AVG_ROUND;
        avg_b_sum = 10'(in_pair.blue) + 10'(in_line.blue) + AVG_ROUND;
    end

    // The biased sums stay within 16 bits, so the top byte is already in range.
    always_comb
    begin
        cb_sum = CB_B_COEF * 16'(a_avg_b_reg) + CHROMA_BIAS
               - CB_R_COEF * 16'(a_avg_r_reg) - CB_G_COEF * 16'(a_avg_g_reg);
        cr_sum = CR_R_COEF * 16'(a_avg_r_reg) + CHROMA_BIAS
               - CR_G_COEF * 16'(a_avg_g_reg) - CR_B_COEF * 16'(a_avg_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_luma_reg  <= luma_next;
            a_avg_r_reg <= avg_r_sum[9:2];
            a_avg_g_reg <= avg_g_sum[9:2];
            a_avg_b_reg <= avg_b_sum[9:2];
            a_ctrl_reg  <= in_ctrl;
        end
        if (a_valid_reg && a_ready)
        begin
            b_luma_reg      <= a_luma_reg;
            b_chroma_reg    <= a_ctrl_reg.chroma;
            b_cb_reg        <= a_ctrl_reg.chroma ? cb_sum[15:8] : '0;
            b_cr_reg        <= a_ctrl_reg.chroma ? cr_sum[15:8] : '0;
            b_frame_end_reg <= a_ctrl_reg.frame_end;
        end
    end

    assign out_valid        = b_valid_reg;
    assign out_luma         = b_luma_reg;
    assign out_chroma_valid = b_chroma_reg;
    assign out_cb           = b_cb_reg;
    assign out_cr           = b_cr_reg;
    assign out_frame_end    = b_frame_end_reg;

endmodule

### hw/rtl/rgb_to_ycbcr420_converter_core.sv
// Top level of the BT.709 RGB to YCbCr 4:2:0 converter.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         tvalid / tready            one BGR pixel per request
// m_axis    out        tvalid / tready            luma, chroma of a 2x2 block, frame end
// apb       in         psel, penable, pwrite      frame_width at 0x0, frame_height at 0x4
//
// One pixel request is taken in every clock cycle while tready is high. Its result is offered on
// m_axis after it has passed the input register with its line-store read, the luma and
// averaging stage, and the chroma stage that loads the result register.
// Reset clears the counters, the left pixel and the stage valids; the line store is not
// cleared, since every entry is written on an even row before an odd row reads it.
// A waiting result stalls only the stages behind it; tready drops once all three are full.
module rgb_to_ycbcr420_converter_core
    import rycc_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // luma [7:0], cb [15:8], cr [23:16]
    output logic        m_axis_tuser,   // chroma_valid [0]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int SLOT_W     = COL_W - 1;
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W      = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;
    localparam int CLAMP_W    = (WIDTH_W > CFG_W) ? WIDTH_W : CFG_W;

    logic [CFG_W-1:0] cfg_width_reg;
    logic [CFG_W-1:0] cfg_height_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    pixel_t           left_reg;

    logic             s1_valid_reg;
    pixel_t           s1_pixel_reg;
    pair_sum_t        s1_pair_reg;
    stage_ctrl_t      s1_ctrl_reg;

    logic             accept;
    logic             cfg_write;
    pixel_t           in_pixel;
    pair_sum_t        pair_sum;
    pair_sum_t        line_sum;
    stage_ctrl_t      ctrl_next;
    logic [CLAMP_W-1:0] width_even;
    logic [CLAMP_W-1:0] width_clamped;
    logic [WIDTH_W-1:0] width_eff;
    logic [CFG_W-1:0] height_even;
    logic [CFG_W-1:0] height_eff;
    logic             row_end;
    logic             last_row;
    logic             line_wr;
    logic             line_rd;
    logic             math_ready;

    logic [PIX_W-1:0] res_luma;
    logic [PIX_W-1:0] res_cb;
    logic [PIX_W-1:0] res_cr;

    // Configuration port. Only paddr[2] picks the register; reads are combinational.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = 32'(cfg_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(cfg_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= CFG_W'(1920);
            cfg_height_reg <= CFG_W'(1080);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  cfg_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: cfg_height_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Frame size: the low bit is dropped and the even part is held to 2..max.
    always_comb
    begin
        width_even = CLAMP_W'({cfg_width_reg[CFG_W-1:1], 1'b0});
        if (width_even == '0)
        begin
            width_clamped = CLAMP_W'(2);
        end
        else if (width_even > CLAMP_W'(MAX_WIDTH))
        begin
            width_clamped = CLAMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = width_even;
        end
        width_eff = width_clamped[WIDTH_W-1:0];

        height_even = {cfg_height_reg[CFG_W-1:1], 1'b0};
        if (height_even == '0)
        begin
            height_eff = CFG_W'(2);
        end
        else if (height_even > CFG_W'(MAX_HEIGHT))
        begin
            height_eff = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_even;
        end
    end

    // Raster position. A count at or past the last index ends the row or the frame,
    // which also covers a size that shrank in the middle of a frame.
    assign row_end  = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(width_eff);
    assign last_row = (CFG_W'(row_reg) + CFG_W'(1)) >= height_eff;

    always_comb
    begin
        if (row_end)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_pixel = pixel_t'(s_axis_tdata);

    // Horizontal pair sum of this pixel and the one to its left.
    always_comb
    begin
        pair_sum.red   = SUM_W'(in_pixel.red) + SUM_W'(left_reg.red);
        pair_sum.green = SUM_W'(in_pixel.green) + SUM_W'(left_reg.green);
        pair_sum.blue  = SUM_W'(in_pixel.blue) + SUM_W'(left_reg.blue);
        ctrl_next.chroma    = col_reg[0] && row_reg[0];
        ctrl_next.frame_end = row_end && last_row;
    end

    // Odd columns of even rows store their pair sums; odd columns of odd rows fetch them.
    assign line_wr = accept && col_reg[0] && !row_reg[0];
    assign line_rd = accept && col_reg[0] && row_reg[0];

    rycc_line_store #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (line_wr),
        .rd_en   (line_rd),
        .addr    (col_reg[COL_W-1:1]),
        .wr_data (pair_sum),
        .rd_data (line_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                left_reg <= in_pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= in_pixel;
            s1_pair_reg  <= pair_sum;
            s1_ctrl_reg  <= ctrl_next;
        end
    end

    assign s_axis_tready = !s1_valid_reg || math_ready;

    rycc_color_math u_color_math (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s1_valid_reg),
        .in_ready         (math_ready),
        .in_pixel         (s1_pixel_reg),
        .in_pair          (s1_pair_reg),
        .in_line          (line_sum),
        .in_ctrl          (s1_ctrl_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_luma         (res_luma),
        .out_chroma_valid (m_axis_tuser),
        .out_cb           (res_cb),
        .out_cr           (res_cr),
        .out_frame_end    (m_axis_tlast)
    );

    assign m_axis_tdata = {res_cr, res_cb, res_luma};

endmodule

### hw/rtl/rycc_checker.sv
// Port-level checks of the converter, bound to its top level.
`include "assert_macros.svh"

module rycc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        pready
);

    // A stalled result keeps its whole payload.
    `RYCC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

    // Chroma fields read as zero when no 2x2 block was completed.
    `RYCC_ASSERT_IMPL(a_chroma_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[23:8] == 16'd0, "chroma not zero without a completed block")

    // Limited-range luma always lies in 16..235.
    `RYCC_ASSERT_IMPL(a_luma_range, clk, rst_n, m_axis_tvalid, (m_axis_tdata[7:0] >= 8'd16) && (m_axis_tdata[7:0] <= 8'd235), "luma outside limited range")

    // The register port never inserts wait states.
    `RYCC_ASSERT(a_pready_high, clk, rst_n, pready, "pready dropped")

endmodule

bind rgb_to_ycbcr420_converter_core rycc_checker u_rycc_checker (.*);
